/* hdl/ffba_pkg.sv */
// Shared constants, status codes and controller states of the first-fit byte allocator
`default_nettype none

package ffba_pkg;

	localparam int PAGE_BYTES_DEF = 4096;
	localparam int MIN_BLOCK_DEF  = 8;
	localparam int SIZE_W         = 13;
	localparam int OFF_W          = 12;

	typedef enum logic [1:0] {
		STAT_OK,
		STAT_BAD_SIZE,
		STAT_NO_SPACE,
		STAT_NOT_FOUND
	} status_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_CHECK,
		S_SCAN,
		S_FILL,
		S_FREE_RD,
		S_FREE_CHK,
		S_DONE
	} state_t;

endpackage

`default_nettype wire

/* hdl/ffba_ram.sv */
// Simple dual-port synchronous RAM, one write and one registered read per cycle
`default_nettype none

module ffba_ram #(
	parameter int DEPTH = 4096,
	parameter int WIDTH = 1
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

/* hdl/first_fit_byte_allocator_top.sv */
// First-fit byte allocator: controller, scan and fill datapath, output register
//
// channel   direction  handshake           payload
// request   in         in_valid/in_stall   action, request_size, block_offset
// result    out        out_valid/out_stall status, result_offset
//
// One request at a time. Allocate: a size check, then a scan of the used
// map at one byte a cycle, then the bytes of the block are marked one a cycle.
// Free: a length lookup (read, then check), then the bytes are cleared one a cycle.
// After reset both memories are swept to zero, with in_stall high.
// A result waits in the output register under out_stall; the next request is taken
// meanwhile and holds in its last state only if the register is still full.
`default_nettype none

module first_fit_byte_allocator_top #(
	parameter int PAGE_BYTES = ffba_pkg::PAGE_BYTES_DEF,
	parameter int MIN_BLOCK  = ffba_pkg::MIN_BLOCK_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic                          action,
	input  wire logic [ffba_pkg::SIZE_W-1:0]   request_size,
	input  wire logic [ffba_pkg::OFF_W-1:0]    block_offset,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic [1:0]                         status,
	output logic [ffba_pkg::OFF_W-1:0]         result_offset
);

	localparam int SW   = ffba_pkg::SIZE_W;
	localparam int OW   = ffba_pkg::OFF_W;
	localparam int AW   = $clog2(PAGE_BYTES);
	localparam int MBW  = $clog2(MIN_BLOCK + 1);
	localparam int MW   = SW + MBW;
	localparam int RSH  = SW + 9;
	localparam int RW   = RSH + 1;
	localparam int PW   = SW + RW;
	localparam logic [AW-1:0] LAST = AW'(PAGE_BYTES - 1);
	localparam logic [MW-1:0] MINW = MW'(MIN_BLOCK);
	localparam logic [SW-1:0] MINS = SW'(MIN_BLOCK);
	localparam logic [RW-1:0] RECIP =
		RW'(((longint'(1) << RSH) + longint'(MIN_BLOCK) - longint'(1)) / longint'(MIN_BLOCK));

	ffba_pkg::state_t  state_q, state_nxt;

	logic              action_q;
	logic [SW-1:0]     size_q;
	logic [OW-1:0]     boff_q;
	logic [SW-1:0]     quot_q;
	logic [AW-1:0]     scan_q;
	logic              iss_done_q;
	logic              vld_s1;
	logic [AW-1:0]     addr_s1;
	logic [SW-1:0]     run_len_q;
	logic [AW-1:0]     start_q;
	logic [AW-1:0]     ptr_q;
	logic [SW-1:0]     cnt_q;
	ffba_pkg::status_t res_status_q;
	logic [OW-1:0]     res_off_q;
	logic              out_valid_q;
	ffba_pkg::status_t status_q;
	logic [OW-1:0]     result_offset_q;

	logic              used_we, used_wd, used_re, used_rd;
	logic [AW-1:0]     used_wa;
	logic              bl_we, bl_re;
	logic [AW-1:0]     bl_wa;
	logic [SW-1:0]     bl_wd, bl_rd;

	logic [PW-1:0]     quot_prod;
	logic              size_ok;
	logic              byte_free;
	logic [SW-1:0]     run_nxt;
	logic [AW-1:0]     start_nxt;
	logic              hit, last_byte;
	logic              off_ok;
	logic [AW-1:0]     off_addr;
	logic              res_load;
	ffba_pkg::status_t res_stat_nxt;
	logic              out_load;

	ffba_ram #(.DEPTH(PAGE_BYTES), .WIDTH(1)) u_used (
		.clk   (clk),
		.we    (used_we),
		.waddr (used_wa),
		.wdata (used_wd),
		.re    (used_re),
		.raddr (scan_q),
		.rdata (used_rd)
	);

	ffba_ram #(.DEPTH(PAGE_BYTES), .WIDTH(SW)) u_blen (
		.clk   (clk),
		.we    (bl_we),
		.waddr (bl_wa),
		.wdata (bl_wd),
		.re    (bl_re),
		.raddr (off_addr),
		.rdata (bl_rd)
	);

	assign quot_prod = PW'(request_size) * PW'(RECIP);
	assign size_ok   = (size_q >= MINS) && ((MW'(quot_q) * MINW) == MW'(size_q));
	assign byte_free = !used_rd;
	assign run_nxt   = byte_free ? run_len_q + SW'(1) : '0;
	assign start_nxt = (byte_free && run_len_q == '0) ? addr_s1 : start_q;
	assign hit       = vld_s1 && byte_free && (run_nxt == size_q);
	assign last_byte = vld_s1 && (addr_s1 == LAST);
	assign off_ok    = 32'(boff_q) < 32'(PAGE_BYTES);
	assign off_addr  = AW'(boff_q);
	assign out_load  = (state_q == ffba_pkg::S_DONE) && (!out_valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ffba_pkg::S_CLEAR;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt    = state_q;
		in_stall     = 1'b1;
		used_we      = 1'b0;
		used_wa      = ptr_q;
		used_wd      = 1'b0;
		used_re      = 1'b0;
		bl_we        = 1'b0;
		bl_wa        = ptr_q;
		bl_wd        = '0;
		bl_re        = 1'b0;
		res_load     = 1'b0;
		res_stat_nxt = ffba_pkg::STAT_OK;
		unique case (state_q)
			ffba_pkg::S_CLEAR: begin
				used_we = 1'b1;
				bl_we   = 1'b1;
				if (ptr_q == LAST) begin
					state_nxt = ffba_pkg::S_IDLE;
				end
			end
			ffba_pkg::S_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					state_nxt = action ? ffba_pkg::S_FREE_RD : ffba_pkg::S_CHECK;
				end
			end
			ffba_pkg::S_CHECK: begin
				if (size_ok) begin
					state_nxt = ffba_pkg::S_SCAN;
				end else begin
					state_nxt    = ffba_pkg::S_DONE;
					res_load     = 1'b1;
					res_stat_nxt = ffba_pkg::STAT_BAD_SIZE;
				end
			end
			ffba_pkg::S_SCAN: begin
				used_re = !iss_done_q;
				if (hit) begin
					state_nxt = ffba_pkg::S_FILL;
					bl_we     = 1'b1;
					bl_wa     = start_nxt;
					bl_wd     = size_q;
				end else if (last_byte) begin
					state_nxt    = ffba_pkg::S_DONE;
					res_load     = 1'b1;
					res_stat_nxt = ffba_pkg::STAT_NO_SPACE;
				end
			end
			ffba_pkg::S_FILL: begin
				used_we = 1'b1;
				used_wd = !action_q;
				if (cnt_q == SW'(1)) begin
					state_nxt = ffba_pkg::S_DONE;
					res_load  = 1'b1;
				end
			end
			ffba_pkg::S_FREE_RD: begin
				bl_re = off_ok;
				if (!off_ok) begin
					state_nxt    = ffba_pkg::S_DONE;
					res_load     = 1'b1;
					res_stat_nxt = ffba_pkg::STAT_NOT_FOUND;
				end else begin
					state_nxt = ffba_pkg::S_FREE_CHK;
				end
			end
			ffba_pkg::S_FREE_CHK: begin
				if (bl_rd == '0) begin
					state_nxt    = ffba_pkg::S_DONE;
					res_load     = 1'b1;
					res_stat_nxt = ffba_pkg::STAT_NOT_FOUND;
				end else begin
					state_nxt = ffba_pkg::S_FILL;
					bl_we     = 1'b1;
					bl_wa     = off_addr;
				end
			end
			ffba_pkg::S_DONE: begin
				if (!out_valid_q || !out_stall) begin
					state_nxt = ffba_pkg::S_IDLE;
				end
			end
			default: begin
				state_nxt = ffba_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q      <= '0;
			iss_done_q <= 1'b0;
			vld_s1     <= 1'b0;
		end else begin
			case (state_q)
				ffba_pkg::S_CLEAR: begin
					ptr_q <= ptr_q + AW'(1);
				end
				ffba_pkg::S_CHECK: begin
					iss_done_q <= 1'b0;
					vld_s1     <= 1'b0;
				end
				ffba_pkg::S_SCAN: begin
					vld_s1 <= !iss_done_q;
					if (!iss_done_q && scan_q == LAST) begin
						iss_done_q <= 1'b1;
					end
					if (hit) begin
						ptr_q <= start_nxt;
					end
				end
				ffba_pkg::S_FILL: begin
					ptr_q <= ptr_q + AW'(1);
				end
				ffba_pkg::S_FREE_CHK: begin
					ptr_q <= off_addr;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ffba_pkg::S_IDLE: begin
				action_q <= action;
				size_q   <= request_size;
				boff_q   <= block_offset;
				quot_q   <= quot_prod[RSH +: SW];
			end
			ffba_pkg::S_CHECK: begin
				scan_q    <= '0;
				run_len_q <= '0;
				start_q   <= '0;
			end
			ffba_pkg::S_SCAN: begin
				if (!iss_done_q) begin
					scan_q  <= scan_q + AW'(1);
					addr_s1 <= scan_q;
				end
				if (vld_s1) begin
					run_len_q <= run_nxt;
					start_q   <= start_nxt;
				end
				if (hit) begin
					cnt_q <= size_q;
				end
			end
			ffba_pkg::S_FILL: begin
				cnt_q <= cnt_q - SW'(1);
			end
			ffba_pkg::S_FREE_CHK: begin
				cnt_q   <= bl_rd;
				start_q <= off_addr;
			end
			default: begin
			end
		endcase
		if (res_load) begin
			res_status_q <= res_stat_nxt;
			res_off_q    <= (res_stat_nxt == ffba_pkg::STAT_OK) ? OW'(start_q) : '0;
		end
		if (out_load) begin
			status_q        <= res_status_q;
			result_offset_q <= res_off_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = status_q;
	assign result_offset = result_offset_q;

endmodule

`default_nettype wire

/* tb/ffba_tb_pkg.sv */
// Request action codes shared by the allocator testbench files
package ffba_tb_pkg;

	typedef enum logic {
		ACT_ALLOC,
		ACT_FREE
	} action_t;

endpackage

/* tb/ffba_grant_checker.sv */
// Channel monitor, first-fit page model and result comparison for the byte allocator
module ffba_grant_checker #(
	parameter int PAGE_BYTES = ffba_pkg::PAGE_BYTES_DEF,
	parameter int MIN_BLOCK  = ffba_pkg::MIN_BLOCK_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	input  wire logic                        in_stall,
	input  wire logic                        action,
	input  wire logic [ffba_pkg::SIZE_W-1:0] request_size,
	input  wire logic [ffba_pkg::OFF_W-1:0]  block_offset,
	input  wire logic                        out_valid,
	input  wire logic                        out_stall,
	input  wire logic [1:0]                  status,
	input  wire logic [ffba_pkg::OFF_W-1:0]  result_offset,
	output int                               fail_count,
	output int                               open_count
);
	timeunit 1ns;
	timeprecision 1ps;
	import ffba_pkg::*;
	import ffba_tb_pkg::*;

	typedef struct packed {
		status_t            st;
		logic [OFF_W-1:0]   off;
	} grant_t;

	grant_t            expected_grants[$];
	bit                page_used[PAGE_BYTES];
	logic [SIZE_W-1:0] start_len[PAGE_BYTES];

	function automatic grant_t serve(action_t act, int sz, int off);
		grant_t g;
		int run_start;
		int run_len;
		g.st = STAT_OK;
		g.off = '0;
		run_start = 0;
		run_len = 0;
		if (act == ACT_ALLOC) begin
			if (sz < MIN_BLOCK || sz % MIN_BLOCK != 0) begin
				g.st = STAT_BAD_SIZE;
				return g;
			end
			for (int i = 0; i < PAGE_BYTES && run_len < sz; i++) begin
				if (!page_used[i]) begin
					if (run_len == 0)
						run_start = i;
					run_len++;
				end else begin
					run_len = 0;
				end
			end
			if (run_len < sz) begin
				g.st = STAT_NO_SPACE;
				return g;
			end
			for (int i = 0; i < sz; i++)
				page_used[run_start + i] = 1'b1;
			start_len[run_start] = SIZE_W'(sz);
			g.off = OFF_W'(run_start);
		end else begin
			if (off >= PAGE_BYTES || start_len[off] == '0) begin
				g.st = STAT_NOT_FOUND;
				return g;
			end
			for (int i = 0; i < int'(start_len[off]) && off + i < PAGE_BYTES; i++)
				page_used[off + i] = 1'b0;
			start_len[off] = '0;
			g.off = OFF_W'(off);
		end
		return g;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		grant_t want;
		if (!arst_n) begin
			expected_grants.delete();
			foreach (page_used[i]) begin
				page_used[i] = 1'b0;
				start_len[i] = '0;
			end
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_grants.size() == 0) begin
					fail_count++;
					$display("%0t: unexpected result, status %0d offset %0d",
						$time, status, result_offset);
				end else begin
					want = expected_grants.pop_front();
					if (status !== want.st) begin
						fail_count++;
						$display("%0t: status expected %0d got %0d", $time, want.st, status);
					end
					if (result_offset !== want.off) begin
						fail_count++;
						$display("%0t: result_offset expected %0d got %0d",
							$time, want.off, result_offset);
					end
				end
			end
			if (in_valid && !in_stall)
				expected_grants.push_back(serve(action_t'(action), int'(request_size),
					int'(block_offset)));
		end
		open_count = expected_grants.size();
	end

endmodule

/* tb/tb_first_fit_byte_allocator_top.sv */
// Testbench top: clock, reset, request stimulus and verdict for the first-fit byte allocator
module tb_first_fit_byte_allocator_top;
	timeunit 1ns;
	timeprecision 1ps;
	import ffba_pkg::*;
	import ffba_tb_pkg::*;

	localparam int PAGE            = PAGE_BYTES_DEF;
	localparam int MINB            = MIN_BLOCK_DEF;
	localparam int HOLD_CYCLES     = 5000;
	localparam int RANDOM_REQUESTS = 120;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              in_valid;
	logic              in_stall;
	logic              action;
	logic [SIZE_W-1:0] request_size;
	logic [OFF_W-1:0]  block_offset;
	logic              out_valid;
	logic              out_stall;
	logic [1:0]        status;
	logic [OFF_W-1:0]  result_offset;
	int                fail_count;
	int                open_count;
	int                requests_sent;
	int                results_seen;
	action_t           issued_actions[$];
	logic [OFF_W-1:0]  live_blocks[$];
	bit                steady;
	bit                hold_req;
	bit                hold_done;

	first_fit_byte_allocator_top #(.PAGE_BYTES(PAGE), .MIN_BLOCK(MINB)) dut (.*);

	ffba_grant_checker #(.PAGE_BYTES(PAGE), .MIN_BLOCK(MINB)) grant_check (.*);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	task automatic offer_request(action_t act, logic [SIZE_W-1:0] sz, logic [OFF_W-1:0] off);
		while (!steady && $urandom_range(0, 99) < 35) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		action <= act;
		request_size <= sz;
		block_offset <= off;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		issued_actions.push_back(act);
		requests_sent++;
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (results_seen != requests_sent);
	endtask

	// track live blocks so that frees mostly hit
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			results_seen++;
			if (issued_actions.size() != 0 && issued_actions.pop_front() == ACT_ALLOC &&
					status == STAT_OK)
				live_blocks.push_back(result_offset);
		end
	end

	initial begin
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req && !hold_done) begin
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_done = 1'b1;
			end
			if (steady)
				out_stall <= 1'b0;
			else
				out_stall <= ($urandom_range(0, 99) < 35);
		end
	end

	initial begin
		#25_000_000;
		$display("tb_first_fit_byte_allocator_top: done, errors");
		$finish;
	end

	initial begin
		int r;
		int idx;
		action_t act;
		logic [SIZE_W-1:0] sz;
		logic [OFF_W-1:0] off;
		arst_n = 1'b0;
		in_valid <= 1'b0;
		action <= 1'b0;
		request_size <= '0;
		block_offset <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		offer_request(ACT_ALLOC, SIZE_W'(PAGE), '1);
		offer_request(ACT_ALLOC, SIZE_W'(MINB), '0);
		offer_request(ACT_FREE, '1, '0);
		offer_request(ACT_ALLOC, '0, '0);
		offer_request(ACT_ALLOC, SIZE_W'(MINB - 1), '0);
		offer_request(ACT_ALLOC, SIZE_W'(MINB + MINB / 2), '0);
		offer_request(ACT_ALLOC, '1, '0);
		offer_request(ACT_ALLOC, SIZE_W'((2 ** SIZE_W) - MINB), '0);
		offer_request(ACT_ALLOC, SIZE_W'(MINB), '0);
		offer_request(ACT_ALLOC, SIZE_W'(2 * MINB), '0);
		offer_request(ACT_ALLOC, SIZE_W'(MINB), '0);
		offer_request(ACT_FREE, '0, OFF_W'(MINB));
		offer_request(ACT_ALLOC, SIZE_W'(3 * MINB), '0);
		offer_request(ACT_ALLOC, SIZE_W'(MINB), '0);
		offer_request(ACT_FREE, '0, OFF_W'(MINB + MINB / 2));
		offer_request(ACT_FREE, '0, '1);
		offer_request(ACT_FREE, '0, OFF_W'(MINB));
		offer_request(ACT_FREE, '0, OFF_W'(MINB));
		offer_request(ACT_FREE, '0, '0);
		offer_request(ACT_FREE, '0, OFF_W'(3 * MINB));
		offer_request(ACT_FREE, '0, OFF_W'(4 * MINB));
		offer_request(ACT_ALLOC, SIZE_W'(PAGE - MINB), '0);
		offer_request(ACT_ALLOC, SIZE_W'(2 * MINB), '0);
		offer_request(ACT_FREE, '0, '0);
		drain();
		live_blocks.delete();

		for (int n = 0; n < RANDOM_REQUESTS; n++) begin
			steady = (n >= 60 && n < 85);
			if (n == 20)
				hold_req = 1'b1;
			if (n == 95)
				drain();
			r = $urandom_range(0, 99);
			sz = SIZE_W'($urandom);
			off = OFF_W'($urandom);
			if (r < 45) begin
				act = ACT_ALLOC;
				sz = SIZE_W'(MINB * $urandom_range(1, 16));
			end else if (r < 48) begin
				act = ACT_ALLOC;
				sz = SIZE_W'(MINB * $urandom_range(17, 128));
			end else if (r < 85 && live_blocks.size() != 0) begin
				act = ACT_FREE;
				idx = $urandom_range(0, live_blocks.size() - 1);
				off = live_blocks[idx];
				live_blocks.delete(idx);
			end else if (r < 85) begin
				act = ACT_ALLOC;
				sz = SIZE_W'(MINB * $urandom_range(1, 16));
			end else if (r < 92) begin
				act = ACT_FREE;
			end else if (r < 96) begin
				act = ACT_ALLOC;
			end else begin
				act = ACT_FREE;
				off = OFF_W'(MINB * $urandom_range(0, 63));
			end
			offer_request(act, sz, off);
		end
		steady = 1'b0;
		drain();
		repeat (64) @(posedge clk);

		if (fail_count == 0 && open_count == 0)
			$display("tb_first_fit_byte_allocator_top: done, clean");
		else
			$display("tb_first_fit_byte_allocator_top: done, errors");
		$finish;
	end

endmodule

/* first_fit_byte_allocator_top.f */
hdl/ffba_pkg.sv
hdl/ffba_ram.sv
hdl/first_fit_byte_allocator_top.sv
tb/ffba_tb_pkg.sv
tb/ffba_grant_checker.sv
tb/tb_first_fit_byte_allocator_top.sv
